[rtl/core/pose_motion_gate_hysteresis_core_assert.svh]
// Assertion helpers shared by the pose motion gate modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef POSE_MOTION_GATE_HYSTERESIS_CORE_ASSERT_SVH
`define POSE_MOTION_GATE_HYSTERESIS_CORE_ASSERT_SVH

// Same-cycle implication.
`define PMG_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PMG_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/pmg_pkg.sv]
`default_nettype none

package pmg_pkg;

  // Field widths
  localparam int ANGLE_W  = 16;
  localparam int GATE_W   = 16;
  localparam int SQ_W     = 2 * GATE_W;
  localparam int CNT_W    = 4;
  localparam int CFG_IDX_W = 3;
  localparam int MAG_W    = 15;             // |wrapped difference| <= 23040
  localparam int DIST_W   = 2 * MAG_W + 1;  // sum of three squares

  // Angle wrap limits, 1/128 degree units
  localparam logic signed [ANGLE_W:0] HALF_TURN = 17'sd23040;
  localparam logic signed [ANGLE_W:0] FULL_TURN = 17'sd46080;

  localparam logic [CNT_W-1:0] SETTLE_MAX = '1;

  // Register reset values
  localparam logic [GATE_W-1:0] JUMP_LIMIT_RST = 16'd1536;
  localparam logic [GATE_W-1:0] MOVE_GATE_RST  = 16'd64;
  localparam logic [GATE_W-1:0] STOP_GATE_RST  = 16'd26;
  localparam logic [CNT_W-1:0]  STOP_COUNT_RST = 4'd4;

  localparam logic [SQ_W-1:0] JUMP2_RST = SQ_W'(JUMP_LIMIT_RST) * SQ_W'(JUMP_LIMIT_RST);
  localparam logic [SQ_W-1:0] MOVE2_RST = SQ_W'(MOVE_GATE_RST) * SQ_W'(MOVE_GATE_RST);
  localparam logic [SQ_W-1:0] STOP2_RST = SQ_W'(STOP_GATE_RST) * SQ_W'(STOP_GATE_RST);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_JUMP_LIMIT = 3'd0,
    CFG_MOVE_GATE  = 3'd1,
    CFG_STOP_GATE  = 3'd2,
    CFG_STOP_COUNT = 3'd3
  } cfg_idx_t;

  typedef logic signed [ANGLE_W-1:0] angle_t;

  // Thresholds as held for the datapath (squared)
  typedef struct packed {
    logic [SQ_W-1:0]  jump2;
    logic [SQ_W-1:0]  move2;
    logic [SQ_W-1:0]  stop2;
    logic [CNT_W-1:0] stop_count;
  } cfg_t;

  // Gate state after one transaction
  typedef struct packed {
    angle_t yaw;
    angle_t pitch;
    angle_t roll;
    logic   moving;
    logic   captured;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/pmg_cfg.sv]
`default_nettype none

module pmg_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [pmg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pmg_pkg::GATE_W-1:0]     cfg_wdata,
  output pmg_pkg::cfg_t                       cfg
);
  import pmg_pkg::*;

  logic [SQ_W-1:0]  jump2_r, jump2_nxt;
  logic [SQ_W-1:0]  move2_r, move2_nxt;
  logic [SQ_W-1:0]  stop2_r, stop2_nxt;
  logic [CNT_W-1:0] stop_cnt_r, stop_cnt_nxt;
  logic [SQ_W-1:0]  wdata_sq;

  // Square the written threshold once, at write time
  assign wdata_sq = SQ_W'(cfg_wdata) * SQ_W'(cfg_wdata);

  // Decode the register write; unknown indexes are dropped
  always_comb begin
    jump2_nxt    = jump2_r;
    move2_nxt    = move2_r;
    stop2_nxt    = stop2_r;
    stop_cnt_nxt = stop_cnt_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_JUMP_LIMIT: jump2_nxt    = wdata_sq;
        CFG_MOVE_GATE:  move2_nxt    = wdata_sq;
        CFG_STOP_GATE:  stop2_nxt    = wdata_sq;
        CFG_STOP_COUNT: stop_cnt_nxt = cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jump2_r    <= JUMP2_RST;
      move2_r    <= MOVE2_RST;
      stop2_r    <= STOP2_RST;
      stop_cnt_r <= STOP_COUNT_RST;
    end else begin
      jump2_r    <= jump2_nxt;
      move2_r    <= move2_nxt;
      stop2_r    <= stop2_nxt;
      stop_cnt_r <= stop_cnt_nxt;
    end
  end

  assign cfg.jump2      = jump2_r;
  assign cfg.move2      = move2_r;
  assign cfg.stop2      = stop2_r;
  assign cfg.stop_count = stop_cnt_r;

endmodule

`default_nettype wire

[rtl/core/pmg_dist.sv]
`default_nettype none

module pmg_dist (
  input  wire pmg_pkg::angle_t            yaw,
  input  wire pmg_pkg::angle_t            pitch,
  input  wire pmg_pkg::angle_t            roll,
  input  wire pmg_pkg::angle_t            held_yaw,
  input  wire pmg_pkg::angle_t            held_pitch,
  input  wire pmg_pkg::angle_t            held_roll,
  output logic [pmg_pkg::DIST_W-1:0]      dist2
);
  import pmg_pkg::*;

  // Wrap a difference into +-half turn and return its magnitude.
  // The 17-bit difference is within one turn of the window, so one
  // correction step is enough.
  function automatic logic [MAG_W-1:0] wrap_mag(angle_t a, angle_t b);
    logic signed [ANGLE_W:0] d;
    logic signed [ANGLE_W:0] w;
    logic signed [ANGLE_W:0] m;
    d = {a[ANGLE_W-1], a} - {b[ANGLE_W-1], b};
    if (d > HALF_TURN)
      w = d - FULL_TURN;
    else if (d < -HALF_TURN)
      w = d + FULL_TURN;
    else
      w = d;
    m = w[ANGLE_W] ? -w : w;
    return m[MAG_W-1:0];
  endfunction

  logic [MAG_W-1:0]   mag_y, mag_p, mag_r;
  logic [2*MAG_W-1:0] sq_y, sq_p, sq_r;

  assign mag_y = wrap_mag(yaw,   held_yaw);
  assign mag_p = wrap_mag(pitch, held_pitch);
  assign mag_r = wrap_mag(roll,  held_roll);

  // Three independent squares
  assign sq_y = mag_y * mag_y;
  assign sq_p = mag_p * mag_p;
  assign sq_r = mag_r * mag_r;

  // Squared distance
  assign dist2 = DIST_W'(sq_y) + DIST_W'(sq_p) + DIST_W'(sq_r);

endmodule

`default_nettype wire

[rtl/core/pmg_gate.sv]
`default_nettype none

`include "pose_motion_gate_hysteresis_core_assert.svh"

module pmg_gate (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       upd,
  input  wire logic                       in_ok,
  input  wire pmg_pkg::angle_t            in_yaw,
  input  wire pmg_pkg::angle_t            in_pitch,
  input  wire pmg_pkg::angle_t            in_roll,
  input  wire logic [pmg_pkg::DIST_W-1:0] dist2,
  input  wire pmg_pkg::cfg_t              cfg,
  output pmg_pkg::angle_t                 held_yaw,
  output pmg_pkg::angle_t                 held_pitch,
  output pmg_pkg::angle_t                 held_roll,
  output pmg_pkg::res_t                   res
);
  import pmg_pkg::*;

  angle_t           yaw_r, yaw_nxt;
  angle_t           pitch_r, pitch_nxt;
  angle_t           roll_r, roll_nxt;
  logic             captured_r, captured_nxt;
  logic             moving_r, moving_nxt;
  logic [CNT_W-1:0] settle_r, settle_nxt;
  logic [SQ_W-1:0]  dist_ext;
  logic             below_jump, above_move, below_stop;
  logic [CNT_W-1:0] settle_inc;

  assign dist_ext   = SQ_W'(dist2);
  assign below_jump = dist_ext < cfg.jump2;
  assign above_move = dist_ext > cfg.move2;
  assign below_stop = dist_ext < cfg.stop2;
  assign settle_inc = (settle_r == SETTLE_MAX) ? settle_r : settle_r + 1'b1;

  // Decide the next held pose and motion state
  always_comb begin
    yaw_nxt      = yaw_r;
    pitch_nxt    = pitch_r;
    roll_nxt     = roll_r;
    captured_nxt = captured_r;
    moving_nxt   = moving_r;
    settle_nxt   = settle_r;
    if (in_ok) begin
      priority if (!captured_r) begin
        // first valid pose is taken as it stands
        yaw_nxt      = in_yaw;
        pitch_nxt    = in_pitch;
        roll_nxt     = in_roll;
        captured_nxt = 1'b1;
      end else if (below_jump && above_move) begin
        // snap to the new pose and start moving
        yaw_nxt    = in_yaw;
        pitch_nxt  = in_pitch;
        roll_nxt   = in_roll;
        moving_nxt = 1'b1;
        settle_nxt = '0;
      end else if (below_jump && moving_r) begin
        // track while moving; count settling frames
        yaw_nxt   = in_yaw;
        pitch_nxt = in_pitch;
        roll_nxt  = in_roll;
        if (below_stop) begin
          settle_nxt = settle_inc;
          if (settle_inc >= cfg.stop_count) moving_nxt = 1'b0;
        end else begin
          settle_nxt = '0;
        end
      end else begin
        // outlier or at rest: hold
      end
    end
  end

  // Commit the state when the transaction advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r      <= '0;
      pitch_r    <= '0;
      roll_r     <= '0;
      captured_r <= 1'b0;
      moving_r   <= 1'b0;
      settle_r   <= '0;
    end else if (upd) begin
      yaw_r      <= yaw_nxt;
      pitch_r    <= pitch_nxt;
      roll_r     <= roll_nxt;
      captured_r <= captured_nxt;
      moving_r   <= moving_nxt;
      settle_r   <= settle_nxt;
    end
  end

  assign held_yaw   = yaw_r;
  assign held_pitch = pitch_r;
  assign held_roll  = roll_r;

  assign res.yaw      = yaw_nxt;
  assign res.pitch    = pitch_nxt;
  assign res.roll     = roll_nxt;
  assign res.moving   = moving_nxt;
  assign res.captured = captured_nxt;

  `PMG_ASSERT_IMP(a_moving_needs_capture, moving_r, captured_r,
    "moving set without a captured pose")
  `PMG_ASSERT_NXT(a_first_capture_keeps_motion, upd && in_ok && !captured_r,
    captured_r && (moving_r == $past(moving_r)) && (settle_r == $past(settle_r)),
    "first capture changed motion state")

endmodule

`default_nettype wire

[rtl/core/pose_motion_gate_hysteresis_core.sv]
// Pose motion gate: holds a frozen yaw/pitch/roll pose (1/128 degree) with a
// dead zone, outlier rejection and stop hysteresis, and returns one result per
// input transaction (the held pose, moving flag and capture flag after that
// pose). A transaction is taken every cycle unless a held result is stalled;
// each passes the input register, then the result register. The
// rate is set by the combinational loop from the held-pose registers through
// the wrapped differences, three squares, the threshold compares and back to
// the held pose. Thresholds are squared when written through the configuration
// port, which should be written only while the block is idle.
`default_nettype none

`include "pose_motion_gate_hysteresis_core_assert.svh"

module pose_motion_gate_hysteresis_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration port
  input  wire logic                          cfg_we,
  input  wire logic [pmg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pmg_pkg::GATE_W-1:0]    cfg_wdata,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_pose_ok,
  input  wire pmg_pkg::angle_t               in_yaw_in,
  input  wire pmg_pkg::angle_t               in_pitch_in,
  input  wire pmg_pkg::angle_t               in_roll_in,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output pmg_pkg::angle_t                    out_yaw_out,
  output pmg_pkg::angle_t                    out_pitch_out,
  output pmg_pkg::angle_t                    out_roll_out,
  output logic                               out_moving_out,
  output logic                               out_held_valid
);
  import pmg_pkg::*;

  cfg_t              cfg;
  res_t              res;
  angle_t            held_yaw, held_pitch, held_roll;
  logic [DIST_W-1:0] dist2;

  logic   stg_vld_r, stg_vld_nxt;
  logic   stg_ok_r;
  angle_t stg_yaw_r, stg_pitch_r, stg_roll_r;
  logic   out_vld_r, out_vld_nxt;
  res_t   out_res_r;
  logic   in_acc, adv;

  // Advance when the result register is free or being drained
  assign adv      = stg_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = stg_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  assign stg_vld_nxt = in_acc ? 1'b1 : (adv ? 1'b0 : stg_vld_r);
  assign out_vld_nxt = adv ? 1'b1 : (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_ok_r    <= in_pose_ok;
      stg_yaw_r   <= in_yaw_in;
      stg_pitch_r <= in_pitch_in;
      stg_roll_r  <= in_roll_in;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (adv) out_res_r <= res;
  end

  pmg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pmg_dist u_dist (
    .yaw        (stg_yaw_r),
    .pitch      (stg_pitch_r),
    .roll       (stg_roll_r),
    .held_yaw   (held_yaw),
    .held_pitch (held_pitch),
    .held_roll  (held_roll),
    .dist2      (dist2)
  );

  pmg_gate u_gate (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (adv),
    .in_ok      (stg_ok_r),
    .in_yaw     (stg_yaw_r),
    .in_pitch   (stg_pitch_r),
    .in_roll    (stg_roll_r),
    .dist2      (dist2),
    .cfg        (cfg),
    .held_yaw   (held_yaw),
    .held_pitch (held_pitch),
    .held_roll  (held_roll),
    .res        (res)
  );

  assign out_valid      = out_vld_r;
  assign out_yaw_out    = out_res_r.yaw;
  assign out_pitch_out  = out_res_r.pitch;
  assign out_roll_out   = out_res_r.roll;
  assign out_moving_out = out_res_r.moving;
  assign out_held_valid = out_res_r.captured;

  `PMG_ASSERT_IMP(a_no_result_overwrite, out_vld_r && out_stall, !adv,
    "waiting result overwritten")
  `PMG_ASSERT_NXT(a_advance_delivers, adv, out_vld_r,
    "advanced transaction did not reach the result register")

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import pmg_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 120;
  localparam int CHUNK_ITEMS    = 90;
  localparam int N_SETTINGS     = 7;
  localparam int MAX_REPORTS    = 10;
  // Index with no register behind it; writes must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd6;

  // Reference gate: held pose, hysteresis state and thresholds, plus the
  // held poses still owed by the block
  class gate_scoreboard;
    angle_t             hold_yaw;
    angle_t             hold_pitch;
    angle_t             hold_roll;
    bit                 captured;
    bit                 moving;
    bit [CNT_W-1:0]     settled;
    bit [GATE_W-1:0]    jump_lim;
    bit [GATE_W-1:0]    move_lim;
    bit [GATE_W-1:0]    stop_lim;
    bit [CNT_W-1:0]     settle_need;
    res_t               pose_due[$];
    int                 errors;

    function new();
      jump_lim    = JUMP_LIMIT_RST;
      move_lim    = MOVE_GATE_RST;
      stop_lim    = STOP_GATE_RST;
      settle_need = STOP_COUNT_RST;
      errors      = 0;
    endfunction

    function int pending();
      return pose_due.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [GATE_W-1:0] data);
      case (idx)
        CFG_JUMP_LIMIT: jump_lim = data;
        CFG_MOVE_GATE:  move_lim = data;
        CFG_STOP_GATE:  stop_lim = data;
        CFG_STOP_COUNT: settle_need = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Fold an angle difference by whole turns into the half-turn range
    static function int wrap_turn(int d);
      while (d > int'(HALF_TURN)) d -= int'(FULL_TURN);
      while (d < -int'(HALF_TURN)) d += int'(FULL_TURN);
      return d;
    endfunction

    // Advance the gate by one accepted pose and queue the held state
    function void note_pose(logic ok, angle_t y, angle_t p, angle_t r);
      int     dy, dp, dr;
      longint dist2, jump2, move2, stop2;
      res_t   due;
      if (ok) begin
        if (!captured) begin
          hold_yaw   = y;
          hold_pitch = p;
          hold_roll  = r;
          captured   = 1'b1;
        end else begin
          dy = wrap_turn(int'(y) - int'(hold_yaw));
          dp = wrap_turn(int'(p) - int'(hold_pitch));
          dr = wrap_turn(int'(r) - int'(hold_roll));
          dist2 = longint'(dy) * dy + longint'(dp) * dp + longint'(dr) * dr;
          jump2 = longint'(jump_lim) * longint'(jump_lim);
          move2 = longint'(move_lim) * longint'(move_lim);
          stop2 = longint'(stop_lim) * longint'(stop_lim);
          // Outliers leave everything frozen
          if (dist2 < jump2) begin
            if (dist2 > move2) begin
              hold_yaw   = y;
              hold_pitch = p;
              hold_roll  = r;
              moving     = 1'b1;
              settled    = '0;
            end else if (moving) begin
              hold_yaw   = y;
              hold_pitch = p;
              hold_roll  = r;
              if (dist2 < stop2) begin
                if (settled != SETTLE_MAX) settled++;
                if (settled >= settle_need) moving = 1'b0;
              end else begin
                settled = '0;
              end
            end
          end
        end
      end
      due.yaw      = captured ? hold_yaw : '0;
      due.pitch    = captured ? hold_pitch : '0;
      due.roll     = captured ? hold_roll : '0;
      due.moving   = moving;
      due.captured = captured;
      pose_due.push_back(due);
    endfunction

    // Compare one accepted result with the oldest held pose owed
    function void check_result(res_t got);
      res_t want;
      if (pose_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("tb: unexpected result yaw %0d pitch %0d roll %0d mv %b hv %b",
                   got.yaw, got.pitch, got.roll, got.moving, got.captured);
        return;
      end
      want = pose_due.pop_front();
      if (got.yaw !== want.yaw || got.pitch !== want.pitch || got.roll !== want.roll ||
          got.moving !== want.moving || got.captured !== want.captured) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("tb: mismatch exp %0d %0d %0d mv %b hv %b / got %0d %0d %0d mv %b hv %b",
                   want.yaw, want.pitch, want.roll, want.moving, want.captured,
                   got.yaw, got.pitch, got.roll, got.moving, got.captured);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GATE_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_pose_ok = 1'b0;
  angle_t               in_yaw_in = '0;
  angle_t               in_pitch_in = '0;
  angle_t               in_roll_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  angle_t               out_yaw_out;
  angle_t               out_pitch_out;
  angle_t               out_roll_out;
  logic                 out_moving_out;
  logic                 out_held_valid;

  gate_scoreboard gate_sb = new();

  int     tx_idle_pct = 0;
  int     rx_idle_pct = 0;
  int     hold_len = 0;
  int     cur_jump = JUMP_LIMIT_RST;
  int     cur_move = MOVE_GATE_RST;
  int     cur_stop = STOP_GATE_RST;
  angle_t anchor_yaw, anchor_pitch, anchor_roll;

  pose_motion_gate_hysteresis_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pose_ok     (in_pose_ok),
    .in_yaw_in      (in_yaw_in),
    .in_pitch_in    (in_pitch_in),
    .in_roll_in     (in_roll_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_yaw_out    (out_yaw_out),
    .out_pitch_out  (out_pitch_out),
    .out_roll_out   (out_roll_out),
    .out_moving_out (out_moving_out),
    .out_held_valid (out_held_valid)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Track register writes, accepted poses and accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) gate_sb.write_reg(cfg_index, cfg_wdata);
      if (in_valid && !in_stall)
        gate_sb.note_pose(in_pose_ok, in_yaw_in, in_pitch_in, in_roll_in);
      if (out_valid && !out_stall)
        gate_sb.check_result('{yaw: out_yaw_out, pitch: out_pitch_out, roll: out_roll_out,
                               moving: out_moving_out, captured: out_held_valid});
    end
  end

  // Drive the result stall: random, or a long hold-off when requested
  initial begin : rx_stall_gen
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: errors");
    $finish;
  end

  // Offer one pose and hold it until accepted
  task automatic send_pose(logic ok, angle_t y, angle_t p, angle_t r);
    in_valid    <= 1'b1;
    in_pose_ok  <= ok;
    in_yaw_in   <= y;
    in_pitch_in <= p;
    in_roll_in  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (gate_sb.pending() != 0) @(posedge clk);
  endtask

  task automatic program_gates(logic [GATE_W-1:0] jump, logic [GATE_W-1:0] move,
                               logic [GATE_W-1:0] stop, logic [CNT_W-1:0] frames);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_JUMP_LIMIT;
    cfg_wdata <= jump;
    @(posedge clk);
    cfg_index <= CFG_MOVE_GATE;
    cfg_wdata <= move;
    @(posedge clk);
    cfg_index <= CFG_STOP_GATE;
    cfg_wdata <= stop;
    @(posedge clk);
    cfg_index <= CFG_STOP_COUNT;
    cfg_wdata <= GATE_W'(frames);
    @(posedge clk);
    // Unmapped index must not disturb anything
    cfg_index <= CFG_SPARE;
    cfg_wdata <= GATE_W'($urandom);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_jump = jump;
    cur_move = move;
    cur_stop = stop;
  endtask

  task automatic program_setting(int n);
    case (n)
      0: program_gates(16'd1536, 16'd64, 16'd26, 4'd4);
      1: program_gates(16'd40000, 16'd40000, 16'd40000, 4'd15);
      2: program_gates(16'd0, 16'd0, 16'd0, 4'd1);
      3: program_gates(16'd40000, 16'd0, 16'd40000, 4'd0);
      4: program_gates(16'd3000, 16'd200, 16'd150, 4'd15);
      5: program_gates(16'd800, 16'd30, 16'd30, 4'd2);
      default: program_gates(16'd2000, 16'd100, 16'd0, 4'd1);
    endcase
  endtask

  // Random step around the anchor, folded back into the half-turn range
  function automatic angle_t near_angle(angle_t base, int spread);
    int v;
    v = int'(base) + int'($urandom_range(2 * spread)) - spread;
    while (v > int'(HALF_TURN)) v -= int'(FULL_TURN);
    while (v < -int'(HALF_TURN)) v += int'(FULL_TURN);
    return angle_t'(v);
  endfunction

  // Mostly well-formed motion around the held pose, some noise and outliers
  task automatic random_item();
    int     pick, spread;
    logic   ok;
    angle_t y, p, r;
    ok     = 1'b1;
    spread = 0;
    pick   = $urandom_range(99);
    if (pick < 13) begin
      ok = (pick >= 10);
      y  = angle_t'($urandom);
      p  = angle_t'($urandom);
      r  = angle_t'($urandom);
    end else begin
      if (pick < 45)      spread = cur_stop / 2;
      else if (pick < 65) spread = cur_move / 2;
      else if (pick < 88) spread = cur_jump / 2;
      else                spread = int'(HALF_TURN);
      if (spread > int'(HALF_TURN)) spread = int'(HALF_TURN);
      y = near_angle(anchor_yaw, spread);
      p = near_angle(anchor_pitch, spread);
      r = near_angle(anchor_roll, spread);
      if (pick < 88) begin
        anchor_yaw   = y;
        anchor_pitch = p;
        anchor_roll  = r;
      end
    end
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    send_pose(ok, y, p, r);
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset thresholds: capture, wrap, gate edges, settling, outlier edge
    send_pose(1'b0, 16'sh7FFF, 16'sh8000, 16'sd12345);
    send_pose(1'b1, 16'sd23040, -16'sd23040, 16'sd0);
    send_pose(1'b1, -16'sd23040, 16'sd23040, 16'sd0);
    send_pose(1'b1, -16'sd22976, 16'sd23040, 16'sd0);
    send_pose(1'b1, -16'sd22975, -16'sd23040, 16'sd0);
    send_pose(1'b1, -16'sd22975, -16'sd23040, 16'sd26);
    repeat (4) send_pose(1'b1, -16'sd22975, -16'sd23040, 16'sd26);
    send_pose(1'b1, -16'sd22975, -16'sd23040, 16'sd1562);
    send_pose(1'b0, angle_t'($urandom), angle_t'($urandom), angle_t'($urandom));
    send_pose(1'b1, -16'sd22975, -16'sd23040, 16'sd1561);
    drain();

    // Wide gates, zero stop count: half-turn steps and out-of-range angles
    program_gates(16'd40000, 16'd0, 16'd40000, 4'd0);
    send_pose(1'b1, 16'sd0, -16'sd23040, 16'sd1561);
    send_pose(1'b1, 16'sd23040, -16'sd23040, 16'sd1561);
    send_pose(1'b1, 16'sd23040, -16'sd23040, 16'sd1561);
    send_pose(1'b1, 16'sh7FFF, 16'sh8000, -16'sd1);
    send_pose(1'b1, 16'sh8000, 16'sh7FFF, 16'sd0);
    send_pose(1'b1, 16'sd0, 16'sd0, 16'sd0);
    send_pose(1'b1, 16'sd0, 16'sd0, 16'sd0);
    drain();

    // Zero gates freeze everything
    program_gates(16'd0, 16'd0, 16'd0, 4'd1);
    send_pose(1'b1, 16'sd100, 16'sd100, 16'sd100);
    send_pose(1'b1, 16'sd0, 16'sd0, 16'sd0);

    // Random part: three idling modes, each across several threshold sets
    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 27 : (mode == 1) ? 53 : 0;
      rx_idle_pct = (mode == 0) ? 53 : (mode == 1) ? 27 : 0;
      for (int k = 0; k < 4; k++) begin
        drain();
        program_setting((mode * 4 + k) % N_SETTINGS);
        anchor_yaw   = gate_sb.hold_yaw;
        anchor_pitch = gate_sb.hold_pitch;
        anchor_roll  = gate_sb.hold_roll;
        if (mode == 2 && k == 0) hold_len = HOLD_CYCLES;
        repeat (CHUNK_ITEMS) random_item();
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (gate_sb.errors == 0 && gate_sb.pending() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/pmg_pkg.sv
rtl/core/pmg_cfg.sv
rtl/core/pmg_dist.sv
rtl/core/pmg_gate.sv
rtl/core/pose_motion_gate_hysteresis_core.sv
dv/tb.sv
